### rtl/core/tna_pkg.sv
// Shared types, constants and helpers for the timetable next-arrival block.
package tna_pkg;

    localparam int TABLE_DEPTH     = 256;
    localparam int TIME_W          = 20;
    localparam int RESULT_W        = 22;
    localparam int SECONDS_PER_DAY = 24 * 3600;
    localparam int MAX_DAYS        = (1 << TIME_W) / SECONDS_PER_DAY;
    // Spans every cell of the row plus the result register.
    localparam int LATENCY         = TABLE_DEPTH + 1;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic CFG_FIXED_MODE     = 1'b0;
    localparam logic CFG_FIXED_DURATION = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] arr_time;
    } t_req;

    typedef struct packed {
        logic [RESULT_W-1:0] result_time;
        logic [1:0]          status;
    } t_rsp;

    typedef struct packed {
        logic              fixed_mode;
        logic [TIME_W-1:0] fixed_duration;
    } t_cfg;

    // Request travelling down the cell row with its running search state.
    typedef struct packed {
        logic              valid;
        logic              operation;
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] arr_time;
        logic              done;      // append: key stored or overwritten
        logic              any;       // query: at least one valid entry seen
        logic [TIME_W-1:0] min_key;
        logic [TIME_W-1:0] min_arr;
        logic              has_succ;
        logic [TIME_W-1:0] succ_key;
        logic [TIME_W-1:0] succ_arr;
    } t_wave;

    // Next midnight strictly after t. The compares are independent; the
    // conditions are monotone so the last one that holds wins.
    function automatic logic [RESULT_W-1:0] next_midnight(input logic [TIME_W-1:0] t);
        logic [RESULT_W-1:0] m;
        m = RESULT_W'(SECONDS_PER_DAY);
        for (int k = 1; k <= MAX_DAYS; k++) begin
            if (RESULT_W'(t) >= RESULT_W'(k * SECONDS_PER_DAY)) begin
                m = RESULT_W'((k + 1) * SECONDS_PER_DAY);
            end
        end
        return m;
    endfunction

endpackage

### rtl/core/tna_cell.sv
// One timetable cell: holds a single entry and updates the passing request.
module tna_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  tna_pkg::t_wave i_wave,
    output tna_pkg::t_wave o_wave
);
    import tna_pkg::*;

    logic              r_valid;
    logic [TIME_W-1:0] r_key;
    logic [TIME_W-1:0] r_arr;
    logic              n_valid;
    logic [TIME_W-1:0] n_key;
    logic [TIME_W-1:0] n_arr;
    t_wave             r_wave;
    t_wave             n_wave;

    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        n_arr   = r_arr;
        n_wave  = i_wave;
        if (i_wave.valid && i_wave.operation == OP_APPEND && !i_wave.done) begin
            if (r_valid && r_key == i_wave.start_time) begin
                n_arr       = i_wave.arr_time;
                n_wave.done = 1'b1;
            end else if (!r_valid) begin
                // valid entries are contiguous: first free cell takes the key
                n_valid     = 1'b1;
                n_key       = i_wave.start_time;
                n_arr       = i_wave.arr_time;
                n_wave.done = 1'b1;
            end
        end
        if (i_wave.valid && i_wave.operation == OP_QUERY && r_valid) begin
            n_wave.any = 1'b1;
            if (!i_wave.any || r_key < i_wave.min_key) begin
                n_wave.min_key = r_key;
                n_wave.min_arr = r_arr;
            end
            if (r_key > i_wave.start_time && (!i_wave.has_succ || r_key < i_wave.succ_key)) begin
                n_wave.has_succ = 1'b1;
                n_wave.succ_key = r_key;
                n_wave.succ_arr = r_arr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_wave  <= '0;
        end else begin
            r_valid <= n_valid;
            r_wave  <= n_wave;
        end
        r_key <= n_key;
        r_arr <= n_arr;
    end

    assign o_wave = r_wave;

endmodule

### rtl/core/tna_result.sv
// Result stage: turns the request leaving the cell row into a response.
module tna_result (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tna_pkg::t_wave i_wave,
    input  tna_pkg::t_cfg  i_cfg,
    output logic           o_done,
    output tna_pkg::t_rsp  o_rsp
);
    import tna_pkg::*;

    logic r_done;
    t_rsp r_rsp;
    t_rsp n_rsp;

    always_comb begin
        n_rsp.result_time = '0;
        n_rsp.status      = ST_OK;
        if (i_wave.operation == OP_APPEND) begin
            n_rsp.status = i_wave.done ? ST_OK : ST_FULL;
        end else if (i_cfg.fixed_mode) begin
            n_rsp.result_time = RESULT_W'(i_wave.start_time) + RESULT_W'(i_cfg.fixed_duration);
        end else if (!i_wave.any) begin
            n_rsp.status = ST_EMPTY;
        end else if (i_wave.has_succ) begin
            n_rsp.result_time = RESULT_W'(i_wave.succ_arr);
        end else begin
            n_rsp.result_time = next_midnight(i_wave.start_time) + RESULT_W'(i_wave.min_arr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_wave.valid;
        end
        r_rsp <= n_rsp;
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

### rtl/core/timetable_next_arrival_top.sv
// Top level of the timetable next-arrival block: cell row, result stage, registers.
//
//  channel   direction  handshake                  payload
//  request   in         start & !busy              i_req  (t_req)
//  response  out        o_done, one cycle          o_rsp  (t_rsp)
//  config    in         i_cfg_we, no wait          i_cfg_idx, i_cfg_wdata
//
// Each request walks the row of TABLE_DEPTH cells, one cell per cycle, then
// the result register, which raises its response strobe.
// A new request may enter every cycle that busy is low: requests follow each
// other down the row in order, so each cell sees every earlier request first.
// Synchronous reset clears the valid bits of all cells at once; busy is high
// during reset and until the first edge after release. The receiver cannot stall.
module timetable_next_arrival_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  tna_pkg::t_req               i_req,
    output logic                        o_done,
    output tna_pkg::t_rsp               o_rsp,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [tna_pkg::TIME_W-1:0]  i_cfg_wdata
);
    import tna_pkg::*;

    logic  r_ready;
    t_cfg  r_cfg;
    t_wave w_chain [TABLE_DEPTH+1];

    // Hold off requests until the first edge that sees reset released.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
        end else begin
            r_ready <= 1'b1;
        end
    end

    assign busy = !r_ready;

    // Register writes: only while no request is in flight, up to the user; not enforced.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FIXED_MODE:     r_cfg.fixed_mode     <= i_cfg_wdata[0];
                CFG_FIXED_DURATION: r_cfg.fixed_duration <= i_cfg_wdata;
            endcase
        end
    end

    // Launch a fresh request with an empty search state.
    always_comb begin
        w_chain[0]            = '0;
        w_chain[0].valid      = start && !busy;
        w_chain[0].operation  = i_req.operation;
        w_chain[0].start_time = i_req.start_time;
        w_chain[0].arr_time   = i_req.arr_time;
    end

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        tna_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_wave (w_chain[g]),
            .o_wave (w_chain[g+1])
        );
    end

    // Drop the search state into a response; fixed mode is read here.
    tna_result u_result (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_wave (w_chain[TABLE_DEPTH]),
        .i_cfg  (r_cfg),
        .o_done (o_done),
        .o_rsp  (o_rsp)
    );

endmodule

### rtl/core/tna_checker.sv
// Port-level checks for the timetable next-arrival block, bound to the top level.
module tna_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input tna_pkg::t_req i_req,
    input logic          o_done,
    input tna_pkg::t_rsp o_rsp
);
    import tna_pkg::*;

    logic w_acc;
    assign w_acc = start && !busy;

    a_no_done_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("response strobe right after reset");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |-> ##LATENCY o_done)
        else $error("accepted request gave no response on time");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(w_acc, LATENCY))
        else $error("response without a matching request");

    a_append_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(i_req.operation == OP_APPEND, LATENCY))
            |-> (o_rsp.result_time == '0 && o_rsp.status != ST_EMPTY))
        else $error("append response carries a time or an empty flag");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_rsp.status == ST_OK || o_rsp.status == ST_FULL
                    || (o_rsp.status == ST_EMPTY && o_rsp.result_time == '0)))
        else $error("bad status code or empty-table response with a time");

endmodule

bind timetable_next_arrival_top tna_checker u_tna_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .start  (start),
    .busy   (busy),
    .i_req  (i_req),
    .o_done (o_done),
    .o_rsp  (o_rsp)
);

### tb/timetable_next_arrival_top_tb.sv
// Self-checking testbench for the timetable next-arrival block: directed and random requests.
module timetable_next_arrival_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tna_pkg::*;

    // Generous ceiling on the whole run, many times the slowest legal run.
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;
    // Upper bound of fresh departure keys while the table fills, so that many
    // queries start after the latest departure and take the midnight path.
    localparam int unsigned FILL_KEY_MAX = 600000;

    // ------------------------------------------------------------------
    // Clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------
    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              start       = 1'b0;
    t_req              i_req       = '0;
    logic              i_cfg_we    = 1'b0;
    logic              i_cfg_idx   = 1'b0;
    logic [TIME_W-1:0] i_cfg_wdata = '0;
    logic              busy;
    logic              o_done;
    t_rsp              o_rsp;

    always #5 i_clk = ~i_clk;

    timetable_next_arrival_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_done      (o_done),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Shadow timetable: our own copy of the table and the registers
    // ------------------------------------------------------------------
    logic [TIME_W-1:0] tt_key [TABLE_DEPTH];
    logic [TIME_W-1:0] tt_arr [TABLE_DEPTH];
    int unsigned       tt_count = 0;
    logic              shadow_fixed_mode = 1'b0;
    logic [TIME_W-1:0] shadow_fixed_duration = '0;

    // Requests waiting to be driven, and responses still owed by the block.
    t_req pending_req_q [$];
    t_rsp owed_rsp_q [$];

    // Keys the stimulus has planned to append, in order, without repeats.
    logic [TIME_W-1:0] planned_keys [$];

    int unsigned send_idle_pct = 0;
    int unsigned cycle_cnt     = 0;
    int unsigned n_errors      = 0;
    int unsigned n_appends     = 0;
    int unsigned n_queries     = 0;
    int unsigned n_dropped     = 0;
    int unsigned n_empty       = 0;
    int unsigned n_wrapped     = 0;

    // Apply one request to the shadow timetable and return the response it owes.
    function automatic t_rsp timetable_apply(input t_req r);
        t_rsp              rsp;
        int                hit;
        logic              have_succ;
        logic [TIME_W-1:0] succ_key;
        logic [TIME_W-1:0] succ_arr;
        logic [TIME_W-1:0] min_key;
        logic [TIME_W-1:0] min_arr;
        int unsigned       sum;
        rsp.result_time = '0;
        rsp.status      = ST_OK;
        if (r.operation == OP_APPEND) begin
            n_appends++;
            hit = -1;
            for (int i = 0; i < tt_count; i++) begin
                if (hit < 0 && tt_key[i] == r.start_time) hit = i;
            end
            if (hit >= 0) begin
                // Known departure: overwrite, even on a full table.
                tt_arr[hit] = r.arr_time;
            end else if (tt_count >= TABLE_DEPTH) begin
                // New departure on a full table: drop it.
                rsp.status = ST_FULL;
                n_dropped++;
            end else begin
                tt_key[tt_count] = r.start_time;
                tt_arr[tt_count] = r.arr_time;
                tt_count++;
            end
        end else begin
            n_queries++;
            if (shadow_fixed_mode) begin
                // Fixed duration: the table is not consulted at all.
                sum = int'(r.start_time) + int'(shadow_fixed_duration);
                rsp.result_time = RESULT_W'(sum);
            end else if (tt_count == 0) begin
                rsp.status = ST_EMPTY;
                n_empty++;
            end else begin
                have_succ = 1'b0;
                succ_key  = '0;
                succ_arr  = '0;
                min_key   = tt_key[0];
                min_arr   = tt_arr[0];
                for (int i = 0; i < tt_count; i++) begin
                    if (tt_key[i] < min_key) begin
                        min_key = tt_key[i];
                        min_arr = tt_arr[i];
                    end
                    if (tt_key[i] > r.start_time && (!have_succ || tt_key[i] < succ_key)) begin
                        have_succ = 1'b1;
                        succ_key  = tt_key[i];
                        succ_arr  = tt_arr[i];
                    end
                end
                if (have_succ) begin
                    rsp.result_time = RESULT_W'(succ_arr);
                end else begin
                    // No later departure today: wait for the first one after midnight.
                    sum = (int'(r.start_time) / SECONDS_PER_DAY + 1) * SECONDS_PER_DAY
                          + int'(min_arr);
                    rsp.result_time = RESULT_W'(sum);
                    n_wrapped++;
                end
            end
        end
        return rsp;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("MISMATCH at cycle %0d: %s got %0d expected %0d", cycle_cnt, what, got, want);
        n_errors++;
    endtask

    // ------------------------------------------------------------------
    // Driver: present queued requests, hold each until busy lets it in
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_p
        logic holding;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            holding = start;
            if (start && !busy) begin
                // Accepted at this edge: predict now, in acceptance order.
                owed_rsp_q.push_back(timetable_apply(i_req));
                holding = 1'b0;
            end
            // Assign start once per edge, so a back-to-back request keeps it high.
            if (!holding) begin
                if (pending_req_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_req <= pending_req_q.pop_front();
                    start <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every response strobe is checked against the oldest owed one
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_p
        t_rsp want;
        if (i_rst_n && o_done !== 1'b0) begin
            if (o_done !== 1'b1) begin
                report_mismatch("response strobe unknown", 0, 1);
            end else if (owed_rsp_q.size() == 0) begin
                report_mismatch("response with nothing outstanding, result_time",
                                o_rsp.result_time, 0);
            end else begin
                want = owed_rsp_q.pop_front();
                if (o_rsp.result_time !== want.result_time)
                    report_mismatch("result_time", o_rsp.result_time, want.result_time);
                if (o_rsp.status !== want.status)
                    report_mismatch("status", o_rsp.status, want.status);
            end
        end
    end

    // Watchdog: end the run if the block stops answering.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d responses outstanding",
                     cycle_cnt, owed_rsp_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Write one register; only ever called while the block is idle.
    task automatic write_reg(input logic idx, input logic [TIME_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        if (idx == CFG_FIXED_MODE) shadow_fixed_mode = data[0];
        else shadow_fixed_duration = data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_mode(input logic fixed, input logic [TIME_W-1:0] duration);
        write_reg(CFG_FIXED_MODE, TIME_W'(fixed));
        write_reg(CFG_FIXED_DURATION, duration);
    endtask

    // Wait until every queued request is in and every response has come back;
    // look just after each edge, once the driver and monitor have settled.
    task automatic drain();
        do begin
            @(posedge i_clk);
            #1;
        end while (pending_req_q.size() != 0 || start || owed_rsp_q.size() != 0);
    endtask

    function automatic bit is_planned(input logic [TIME_W-1:0] k);
        foreach (planned_keys[i]) if (planned_keys[i] == k) return 1'b1;
        return 1'b0;
    endfunction

    function automatic void queue_req(input logic op, input logic [TIME_W-1:0] t,
                                      input logic [TIME_W-1:0] arr);
        t_req r;
        r.operation  = op;
        r.start_time = t;
        r.arr_time   = arr;
        if (op == OP_APPEND && !is_planned(t)) planned_keys.push_back(t);
        pending_req_q.push_back(r);
    endfunction

    // Fresh departure key; the last free slot always takes the latest possible key.
    function automatic logic [TIME_W-1:0] fresh_key();
        logic [TIME_W-1:0] k;
        if (planned_keys.size() == TABLE_DEPTH - 1 && !is_planned(TIME_MAX)) return TIME_MAX;
        if (planned_keys.size() >= TABLE_DEPTH) return TIME_W'($urandom);
        do k = TIME_W'($urandom_range(0, FILL_KEY_MAX));
        while (is_planned(k));
        return k;
    endfunction

    function automatic logic [TIME_W-1:0] pick_arrival();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 20) return TIME_MAX;
        return TIME_W'($urandom);
    endfunction

    // Query start: aim at stored keys, midnight boundaries and the extremes.
    function automatic logic [TIME_W-1:0] pick_start();
        int unsigned r;
        int          offset;
        r      = $urandom_range(0, 99);
        offset = int'($urandom_range(0, 2)) - 1;
        if (r < 35 || planned_keys.size() == 0 && r < 65) return TIME_W'($urandom);
        if (r < 65)
            return TIME_W'(int'(planned_keys[$urandom_range(0, planned_keys.size() - 1)])
                           + offset);
        if (r < 85) return TIME_W'(int'($urandom_range(1, 12)) * SECONDS_PER_DAY + offset);
        if (r < 93) return TIME_MAX;
        return TIME_W'($urandom_range(0, 3));
    endfunction

    // Queue a run of random requests, appends at the given share.
    task automatic queue_random(input int unsigned count, input int unsigned append_pct);
        repeat (count) begin
            if ($urandom_range(0, 99) < append_pct) begin
                // Overwrite a planned key about a third of the time.
                if (planned_keys.size() != 0 && $urandom_range(0, 99) < 35)
                    queue_req(OP_APPEND,
                              planned_keys[$urandom_range(0, planned_keys.size() - 1)],
                              pick_arrival());
                else
                    queue_req(OP_APPEND, fresh_key(), pick_arrival());
            end else begin
                queue_req(OP_QUERY, pick_start(), TIME_W'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty table in lookup mode flags an error.
        send_idle_pct = 29;
        set_mode(1'b0, '0);
        queue_req(OP_QUERY, '0, '0);
        queue_req(OP_QUERY, TIME_MAX, TIME_MAX);
        drain();

        // Fixed mode ignores the empty table; zero duration first.
        set_mode(1'b1, '0);
        queue_req(OP_QUERY, '0, '0);
        queue_req(OP_QUERY, TIME_MAX, '0);
        drain();

        // Largest duration; an append in fixed mode is still stored.
        set_mode(1'b1, TIME_MAX);
        queue_req(OP_QUERY, TIME_MAX, '0);
        queue_req(OP_APPEND, 20'd300000, 20'd7);
        queue_req(OP_QUERY, '0, TIME_MAX);
        drain();

        // Lookup: strict successor, midnight wrap, overwrite of known keys.
        set_mode(1'b0, 20'h5A5A5);
        queue_req(OP_QUERY, '0, '0);
        queue_req(OP_QUERY, 20'd300000, '0);
        queue_req(OP_APPEND, '0, '0);
        queue_req(OP_APPEND, 20'd120000, TIME_MAX);
        queue_req(OP_QUERY, '0, '0);
        queue_req(OP_QUERY, 20'd119999, '0);
        queue_req(OP_QUERY, 20'd120000, '0);
        queue_req(OP_QUERY, 20'd299999, '0);
        queue_req(OP_QUERY, 20'd86399, '0);
        queue_req(OP_QUERY, 20'd345599, '0);
        queue_req(OP_QUERY, 20'd345600, '0);
        queue_req(OP_APPEND, '0, TIME_MAX);
        queue_req(OP_QUERY, TIME_MAX, '0);
        queue_req(OP_APPEND, 20'd300000, '0);
        queue_req(OP_QUERY, 20'd200000, '0);
        drain();

        // Random, append-heavy so the table fills; sender idles now and then.
        set_mode(1'b0, TIME_W'($urandom));
        queue_random(300, 70);
        drain();

        // Sender mostly idle; appends keep filling the table.
        send_idle_pct = 86;
        set_mode(1'b0, TIME_W'($urandom));
        queue_random(250, 55);
        drain();

        // Back to back from here on: fixed mode at the largest duration.
        send_idle_pct = 0;
        set_mode(1'b1, TIME_MAX);
        queue_random(100, 50);
        drain();

        set_mode(1'b1, TIME_W'($urandom));
        queue_random(50, 50);
        drain();

        // Lookup once more on the full table.
        set_mode(1'b0, '0);
        queue_random(120, 40);
        drain();

        // Hold a full pipeline length so a stray late response is still caught.
        repeat (LATENCY + 16) @(posedge i_clk);

        $display("Ran %0d requests: %0d appends (%0d dropped on a full table), %0d queries",
                 n_appends + n_queries, n_appends, n_dropped, n_queries);
        $display("Queries: %0d on an empty table, %0d past the last departure; %0d entries held",
                 n_empty, n_wrapped, tt_count);
        if (n_errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
